>>> rtl/cswa_pkg.sv
// Shared types, register indexes and window coefficients for the cosine-sum window block.
// Used by the controller, the datapath and the top level; depends on nothing else.
`default_nettype none

package cswa_pkg;

	localparam int MAX_WINDOW_DEF = 65536;
	localparam int COS_DEPTH_DEF  = 1024;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP    = 2'd2;

	localparam logic        MODE_FLAT_TOP = 1'b0;
	localparam logic        MODE_BH       = 1'b1;
	localparam logic [16:0] WLEN_RESET    = 17'd1024;
	localparam logic [31:0] STEP_RESET    = 32'd4198404;

	localparam logic [2:0] TERMS_FT = 3'd4;
	localparam logic [2:0] TERMS_BH = 3'd3;

	localparam logic [31:0] PI_HALF_Q30 = 32'd1686629713;

	localparam logic [16:0] FT_A0 = 17'd28256;
	localparam logic [16:0] FT_A1 = 17'd54609;
	localparam logic [16:0] FT_A2 = 17'd36341;
	localparam logic [16:0] FT_A3 = 17'd10955;
	localparam logic [16:0] FT_A4 = 17'd911;
	localparam logic [16:0] BH_A0 = 17'd47022;
	localparam logic [16:0] BH_A1 = 17'd64001;
	localparam logic [16:0] BH_A2 = 17'd18518;
	localparam logic [16:0] BH_A3 = 17'd1531;

	typedef struct packed {
		logic accept;
		logic issue;
		logic mul;
		logic finish;
	} cswa_cmd_t;

	typedef struct packed {
		logic drop;
		logic last_term;
		logic pipe_busy;
		logic out_free;
	} cswa_sts_t;

	function automatic logic [16:0] coef_of(input logic mode, input logic [2:0] k);
		logic [16:0] c;
		case (k)
			3'd0: c = (mode == MODE_BH) ? BH_A0 : FT_A0;
			3'd1: c = (mode == MODE_BH) ? BH_A1 : FT_A1;
			3'd2: c = (mode == MODE_BH) ? BH_A2 : FT_A2;
			3'd3: c = (mode == MODE_BH) ? BH_A3 : FT_A3;
			3'd4: c = FT_A4;
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

>>> rtl/cswa_ctrl.sv
// Sequencing state machine of the cosine-sum window block.
// Depends on cswa_pkg for the command and status structs.
`default_nettype none

module cswa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  cswa_pkg::cswa_sts_t sts,
	output cswa_pkg::cswa_cmd_t cmd
);
	import cswa_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_LOOK  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_OUT   = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
				if (in_valid && !sts.drop) begin
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				cmd.issue = 1'b1;
				if (sts.last_term) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!sts.pipe_busy) begin
					cmd.mul = 1'b1;
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/cswa_dp.sv
// Datapath of the cosine-sum window block: configuration registers, record state,
// cosine table, term accumulator, sample multiplier and output register. Uses cswa_pkg.
`default_nettype none

module cswa_dp #(
	parameter int MaxWindow = cswa_pkg::MAX_WINDOW_DEF,
	parameter int CosDepth  = cswa_pkg::COS_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [cswa_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cswa_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic signed [15:0]                  sample_in,
	input  logic                                record_end,
	output logic signed [15:0]                  sample_out,
	output logic                                out_last,
	output logic                                out_valid,
	input  logic                                out_stall,
	input  cswa_pkg::cswa_cmd_t                 cmd,
	output cswa_pkg::cswa_sts_t                 sts
);
	import cswa_pkg::*;

	localparam int IW = ($clog2(MaxWindow + 1) < 17) ? $clog2(MaxWindow + 1) : 17;
	localparam int DW = $clog2(CosDepth + 1);
	localparam int MW = 30 + DW;

	// Quarter-wave cosine table in Q1.16, built from a truncated Taylor series in Q30.
	wire [16:0] cos_rom [0:CosDepth];

	genvar gi;
	generate
		for (gi = 0; gi <= CosDepth; gi++) begin : g_rom
			localparam logic [63:0] X   = (64'(PI_HALF_Q30) * 64'(gi)) / 64'(CosDepth);
			localparam logic [63:0] X2  = (X * X) >> 30;
			localparam logic [63:0] T1  = (((64'd1 << 30) * X2) >> 30) / 64'd2;
			localparam logic [63:0] T2  = ((T1 * X2) >> 30) / 64'd12;
			localparam logic [63:0] T3  = ((T2 * X2) >> 30) / 64'd30;
			localparam logic [63:0] T4  = ((T3 * X2) >> 30) / 64'd56;
			localparam logic [63:0] T5  = ((T4 * X2) >> 30) / 64'd90;
			localparam logic [63:0] T6  = ((T5 * X2) >> 30) / 64'd132;
			localparam logic [63:0] T7  = ((T6 * X2) >> 30) / 64'd182;
			localparam logic [63:0] T8  = ((T7 * X2) >> 30) / 64'd240;
			localparam logic [63:0] T9  = ((T8 * X2) >> 30) / 64'd306;
			localparam logic [63:0] T10 = ((T9 * X2) >> 30) / 64'd380;
			localparam logic signed [63:0] SUM = 64'sh40000000
				- $signed(T1) + $signed(T2) - $signed(T3) + $signed(T4) - $signed(T5)
				+ $signed(T6) - $signed(T7) + $signed(T8) - $signed(T9) + $signed(T10);
			localparam logic signed [63:0] SUMC = (SUM < 64'sd0) ? 64'sd0 : SUM;
			localparam logic signed [63:0] RND  = (SUMC + 64'sd8192) >>> 14;
			localparam logic signed [63:0] VAL  = (RND > 64'sd65536) ? 64'sd65536 : RND;
			assign cos_rom[gi] = VAL[16:0];
		end
	endgenerate

	logic              mode_q;
	logic [16:0]       wlen_q;
	logic [31:0]       step_q;
	logic [IW-1:0]     idx_q;
	logic [31:0]       phase_q;

	logic signed [15:0] samp_q;
	logic               end_q;
	logic [31:0]        ph_q;
	logic [2:0]         k_q;
	logic signed [34:0] acc_q;
	logic signed [50:0] prod_q;

	logic [DW-1:0]      addr_s1;
	logic               neg_s1;
	logic [16:0]        coef_s1;
	logic               vld_s1;
	logic [16:0]        rom_s2;
	logic               neg_s2;
	logic [16:0]        coef_s2;
	logic               vld_s2;

	logic [31:0]        n_eff_w;
	logic [IW-1:0]      n_eff;
	logic [MW-1:0]      jprod;
	logic [DW-1:0]      j_idx;
	logic [DW-1:0]      jr_idx;
	logic [33:0]        term;
	logic signed [51:0] rsum;
	logic signed [18:0] rq;
	logic signed [15:0] sat;
	logic               last;

	always_comb begin
		n_eff_w = (32'(wlen_q) > 32'(MaxWindow)) ? 32'(MaxWindow) : 32'(wlen_q);
		n_eff   = n_eff_w[IW-1:0];
		jprod   = MW'(ph_q[29:0]) * MW'(CosDepth) + (MW'(1) << 29);
		j_idx   = jprod[MW-1:30];
		jr_idx  = DW'(CosDepth) - j_idx;
		term    = 34'(coef_s2) * 34'(rom_s2);
		rsum    = 52'(prod_q) + (52'sd1 <<< 32);
		rq      = rsum[51:33];
		if (rq > 19'sd32767) begin
			sat = 16'sh7fff;
		end else if (rq < -19'sd32768) begin
			sat = -16'sh8000;
		end else begin
			sat = rq[15:0];
		end
		last = end_q || ((IW + 1)'(idx_q) + (IW + 1)'(1) == (IW + 1)'(n_eff));
	end

	assign sts.drop      = (idx_q >= n_eff);
	assign sts.last_term = (k_q == ((mode_q == MODE_BH) ? TERMS_BH : TERMS_FT));
	assign sts.pipe_busy = vld_s1 || vld_s2;
	assign sts.out_free  = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_FLAT_TOP;
			wlen_q  <= WLEN_RESET;
			step_q  <= STEP_RESET;
			idx_q   <= '0;
			phase_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_WINDOW_MODE:   mode_q <= cfg_data[0];
					REG_WINDOW_LENGTH: wlen_q <= cfg_data[16:0];
					REG_PHASE_STEP:    step_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.accept && sts.drop && record_end) begin
				idx_q   <= '0;
				phase_q <= '0;
			end else if (cmd.finish) begin
				if (end_q) begin
					idx_q   <= '0;
					phase_q <= '0;
				end else begin
					idx_q   <= idx_q + IW'(1);
					phase_q <= phase_q + step_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			vld_s1 <= cmd.issue;
			vld_s2 <= vld_s1;
			if (cmd.finish) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			samp_q <= sample_in;
			end_q  <= record_end;
			ph_q   <= phase_q;
			k_q    <= 3'd1;
			acc_q  <= $signed({2'b00, coef_of(mode_q, 3'd0), 16'd0});
		end else if (cmd.issue) begin
			ph_q <= ph_q + phase_q;
			k_q  <= k_q + 3'd1;
		end
		if (cmd.issue) begin
			addr_s1 <= ph_q[30] ? jr_idx : j_idx;
			neg_s1  <= ph_q[31] ^ ph_q[30] ^ k_q[0];
			coef_s1 <= coef_of(mode_q, k_q);
		end
		rom_s2  <= cos_rom[addr_s1];
		neg_s2  <= neg_s1;
		coef_s2 <= coef_s1;
		if (vld_s2) begin
			if (neg_s2) begin
				acc_q <= acc_q - $signed({1'b0, term});
			end else begin
				acc_q <= acc_q + $signed({1'b0, term});
			end
		end
		if (cmd.mul) begin
			prod_q <= 51'(samp_q) * 51'(acc_q);
		end
		if (cmd.finish) begin
			sample_out <= sat;
			out_last   <= last;
		end
	end

endmodule

`default_nettype wire

>>> rtl/cosine_sum_window_apply_top.sv
// Top level of the cosine-sum window block: joins the controller and the datapath.
// Depends on cswa_pkg, cswa_ctrl and cswa_dp.
//
// Usage: samples enter on sample_in/record_end with in_valid; a transfer happens when
// in_valid is high and in_stall is low. Results leave on sample_out/out_last with
// out_valid; the receiver holds out_stall high to keep a result in the output register.
// Each sample at position n is weighted by the flat-top (mode 0) or Blackman-Harris
// (mode 1) window, rounded and saturated to Q1.15. Samples at or beyond the window
// length give no result, and the block stays ready for the next sample.
// Each sample is worked through in turn: the single cosine table port serves its window
// terms one per cycle through its two-stage read pipe, the terms are summed, and the
// final multiply weights the sample; in_stall stays high until the result is loaded,
// so a new sample is not taken before then.
// A finished result waits in the output register while a new sample is taken; a
// receiver stall holds the block back only once its next result finds that register
// still full, and in_stall stays high while that result waits.
// Reset returns the registers to their defaults and the record position and phase to
// zero. Configuration writes are taken at any time but are meant for an idle block.
`default_nettype none

module cosine_sum_window_apply_top #(
	parameter int MaxWindow = cswa_pkg::MAX_WINDOW_DEF,
	parameter int CosDepth  = cswa_pkg::COS_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [cswa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cswa_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic signed [15:0]              sample_in,
	input  logic                            record_end,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [15:0]              sample_out,
	output logic                            out_last
);
	import cswa_pkg::*;

	cswa_cmd_t cmd;
	cswa_sts_t sts;

	cswa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	cswa_dp #(
		.MaxWindow (MaxWindow),
		.CosDepth  (CosDepth)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.sample_in  (sample_in),
		.record_end (record_end),
		.sample_out (sample_out),
		.out_last   (out_last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.cmd        (cmd),
		.sts        (sts)
	);

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !(out_valid && out_stall))
		else $error("Output register loaded while a stalled result waits.");

	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |-> !(cmd.issue || cmd.mul || cmd.finish))
		else $error("Input transfer overlaps work on an earlier sample.");

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		sts.pipe_busy |-> in_stall)
		else $error("Input taken while table reads are in flight.");

	a_drop_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && sts.drop) |=> !in_stall)
		else $error("Dropped sample did not free the input in one cycle.");

endmodule

`default_nettype wire

>>> test/tb.sv
// Self-checking testbench for cosine_sum_window_apply_top: drives sample records through
// the valid/stall handshake and checks each weighted result against an in-bench predictor.
// Depends on cswa_pkg and cosine_sum_window_apply_top.
`default_nettype none

module tb;
	import cswa_pkg::*;

	localparam int COS_N = COS_DEPTH_DEF;
	localparam int WIN_MAX = MAX_WINDOW_DEF;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	localparam longint FT_C0 = 28256;
	localparam longint FT_C1 = 54609;
	localparam longint FT_C2 = 36341;
	localparam longint FT_C3 = 10955;
	localparam longint FT_C4 = 911;
	localparam longint BH_C0 = 47022;
	localparam longint BH_C1 = 64001;
	localparam longint BH_C2 = 18518;
	localparam longint BH_C3 = 1531;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	typedef struct packed {
		logic [15:0] value;
		logic        boundary;
	} framed_sample_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [15:0] sample_in = '0;
	logic record_end = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [15:0] sample_out;
	logic out_last;

	framed_sample_t sample_feed[$];
	framed_sample_t window_expect_q[$];
	longint cos_tab[0:COS_N];

	logic        m_mode = MODE_FLAT_TOP;
	logic [16:0] m_length = 17'd1024;
	logic [31:0] m_step = 32'd4198404;
	logic [16:0] m_index = '0;
	logic [31:0] m_phase = '0;

	int fed_count = 0;
	int queued_count = 0;
	int fail_count = 0;
	int send_gap = 0;
	int recv_hold = 0;
	bit calm = 1'b0;

	cosine_sum_window_apply_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample_in(sample_in),
		.record_end(record_end),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sample_out(sample_out),
		.out_last(out_last)
	);

	always #5 clk = ~clk;

	initial begin : cos_table_fill
		longint unsigned x, x2, term;
		longint acc;
		for (int i = 0; i <= COS_N; i++) begin
			x = (HALF_PI_Q30 * longint'(i)) / longint'(COS_N);
			x2 = (x * x) >> 30;
			term = 64'd1 << 30;
			acc = longint'(term);
			for (int k = 1; k <= 10; k++) begin
				term = ((term * x2) >> 30) / longint'((2 * k - 1) * (2 * k));
				if (k % 2 == 1) begin
					acc = acc - longint'(term);
				end else begin
					acc = acc + longint'(term);
				end
			end
			if (acc < 0) begin
				acc = 0;
			end
			acc = (acc + 8192) >>> 14;
			if (acc > 65536) begin
				acc = 65536;
			end
			cos_tab[i] = acc;
		end
	end

	function automatic longint cos_q16(input logic [31:0] angle);
		longint unsigned frac, j, jr;
		frac = longint'(angle[29:0]);
		j = (frac * longint'(COS_N) + (64'd1 << 29)) >> 30;
		if (j > COS_N) begin
			j = COS_N;
		end
		jr = COS_N - j;
		case (angle[31:30])
			2'd0: return cos_tab[j];
			2'd1: return -cos_tab[jr];
			2'd2: return -cos_tab[j];
			default: return cos_tab[jr];
		endcase
	endfunction

	// Weights an in-window sample, steps position and phase; a record end clears them.
	function automatic void weigh_sample(input logic [15:0] raw, input logic fin);
		longint neff, w, prod, r;
		logic [31:0] a2, a3, a4;
		framed_sample_t res;
		neff = (m_length > WIN_MAX) ? WIN_MAX : longint'(m_length);
		if (longint'(m_index) >= neff) begin
			if (fin) begin
				m_index = '0;
				m_phase = '0;
			end
			return;
		end
		a2 = m_phase * 32'd2;
		a3 = m_phase * 32'd3;
		a4 = m_phase * 32'd4;
		if (m_mode == MODE_BH) begin
			w = BH_C0 * 65536 - BH_C1 * cos_q16(m_phase) + BH_C2 * cos_q16(a2)
				- BH_C3 * cos_q16(a3);
		end else begin
			w = FT_C0 * 65536 - FT_C1 * cos_q16(m_phase) + FT_C2 * cos_q16(a2)
				- FT_C3 * cos_q16(a3) + FT_C4 * cos_q16(a4);
		end
		prod = longint'($signed(raw)) * w;
		r = (prod + (longint'(1) <<< 32)) >>> 33;
		if (r > 32767) begin
			r = 32767;
		end else if (r < -32768) begin
			r = -32768;
		end
		res.value = r[15:0];
		res.boundary = fin || (longint'(m_index) + 1 == neff);
		window_expect_q.push_back(res);
		if (fin) begin
			m_index = '0;
			m_phase = '0;
		end else begin
			m_index = m_index + 17'd1;
			m_phase = m_phase + m_step;
		end
	endfunction

	always @(posedge clk) begin : driver
		framed_sample_t nxt;
		if (!(in_valid && in_stall)) begin
			if (send_gap > 0) begin
				send_gap = send_gap - 1;
				in_valid <= 1'b0;
			end else if (sample_feed.size() != 0) begin
				nxt = sample_feed.pop_front();
				sample_in <= nxt.value;
				record_end <= nxt.boundary;
				in_valid <= 1'b1;
				if (!calm && $urandom_range(0, 9) == 0) begin
					send_gap = $urandom_range(1, 17);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : receiver
		if (recv_hold > 0) begin
			recv_hold = recv_hold - 1;
		end else if (!calm && $urandom_range(0, 11) == 0) begin
			recv_hold = $urandom_range(1, 17);
		end
		out_stall <= (recv_hold != 0);
	end

	always @(posedge clk) begin : monitor
		framed_sample_t want;
		if (out_valid && !out_stall) begin
			if (window_expect_q.size() == 0) begin
				$error("sample_out: no result expected, got %0d", sample_out);
				fail_count++;
			end else begin
				want = window_expect_q.pop_front();
				if (sample_out !== want.value) begin
					$error("sample_out: expected %0d, got %0d", $signed(want.value),
						sample_out);
					fail_count++;
				end
				if (out_last !== want.boundary) begin
					$error("out_last: expected %0d, got %0d", want.boundary, out_last);
					fail_count++;
				end
			end
		end
		if (in_valid && !in_stall) begin
			weigh_sample(sample_in, record_end);
			fed_count++;
		end
	end

	task automatic feed(input logic [15:0] value, input logic boundary);
		framed_sample_t it;
		it.value = value;
		it.boundary = boundary;
		sample_feed.push_back(it);
		queued_count++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_WINDOW_MODE: m_mode = value[0];
			REG_WINDOW_LENGTH: m_length = value[16:0];
			REG_PHASE_STEP: m_step = value;
			default: ;
		endcase
	endtask

	// The block is idle once every queued sample is taken and every result has left.
	task automatic settle();
		while (fed_count != queued_count || window_expect_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [31:0] step_for(input longint n);
		longint unsigned q;
		q = ((64'd1 << 32) + longint'((n - 1) / 2)) / longint'(n - 1);
		return q[31:0];
	endfunction

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin : stimulus_plan
		int total, rec_len;
		int len_w;
		longint neff;
		logic md;
		logic [31:0] d;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		feed(16'h7FFF, 1'b0);
		feed(16'h8000, 1'b0);
		feed(16'h0000, 1'b0);
		feed(16'h0001, 1'b0);
		feed(16'hFFFF, 1'b0);
		feed(16'h4000, 1'b1);
		settle();

		// Four-point Blackman-Harris: point four flags out_last, later ones drop to record end.
		write_reg(REG_WINDOW_MODE, 32'hFFFF_FFFF);
		write_reg(REG_WINDOW_LENGTH, 32'hABCE_0004);
		write_reg(REG_PHASE_STEP, step_for(4));
		feed(16'h7FFF, 1'b0);
		feed(16'h8000, 1'b0);
		feed(16'h7FFF, 1'b0);
		feed(16'h8000, 1'b0);
		feed(16'h0064, 1'b0);
		feed(16'h00C8, 1'b1);
		feed(16'h7FFF, 1'b1);
		settle();

		write_reg(REG_WINDOW_MODE, 32'h0000_0000);
		write_reg(REG_WINDOW_LENGTH, 32'h0000_0000);
		feed(16'h0005, 1'b0);
		feed(16'h8000, 1'b1);
		settle();

		write_reg(REG_WINDOW_LENGTH, 32'h0000_0001);
		write_reg(REG_PHASE_STEP, 32'h0000_0000);
		feed(16'h7FFF, 1'b0);
		feed(16'h0001, 1'b0);
		feed(16'hFFFB, 1'b1);
		settle();

		write_reg(REG_WINDOW_LENGTH, 32'h0001_FFFF);
		write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
		write_reg(REG_UNUSED, 32'($urandom));
		feed(16'h7FFF, 1'b0);
		feed(16'h8000, 1'b0);
		feed(16'h7FFF, 1'b1);
		settle();

		for (int ph = 0; ph < 8; ph++) begin
			calm = (ph == 7) || ($urandom_range(0, 3) == 0);
			md = 1'($urandom_range(0, 1));
			case ($urandom_range(0, 9))
				0: len_w = $urandom_range(0, 3);
				1: len_w = $urandom_range(65536, 131071);
				2: len_w = $urandom_range(100, 4000);
				default: len_w = $urandom_range(4, 40);
			endcase
			neff = (len_w > WIN_MAX) ? WIN_MAX : len_w;
			d = $urandom;
			d[0] = md;
			write_reg(REG_WINDOW_MODE, d);
			d = $urandom;
			d[16:0] = len_w[16:0];
			write_reg(REG_WINDOW_LENGTH, d);
			if (neff >= 2 && $urandom_range(0, 3) != 0) begin
				d = step_for(neff);
			end else begin
				d = $urandom;
			end
			write_reg(REG_PHASE_STEP, d);
			total = 0;
			while (total < 75) begin
				rec_len = $urandom_range(1, int'((neff > 48) ? 48 : neff) + 3);
				for (int i = 0; i < rec_len; i++) begin
					feed(pick_sample(), i == rec_len - 1);
				end
				total += rec_len;
			end
			settle();
		end

		if (fail_count == 0 && window_expect_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire

>>> sim.f
rtl/cswa_pkg.sv
rtl/cswa_ctrl.sv
rtl/cswa_dp.sv
rtl/cosine_sum_window_apply_top.sv
test/tb.sv
